// ===== rtl/mvp_pkg.sv =====
// Shared types and constants for the MAVLink v1 frame parser.
// No dependencies; used by every module of the parser.
package mvp_pkg;

  localparam logic [7:0] START_BYTE = 8'hFE;

  localparam int unsigned TDATA_W = 56;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_EOF     = 1'b1
  } kind_e;

  typedef struct packed {
    logic [7:0] message_id;
    logic [7:0] component_id;
    logic [7:0] system_id;
    logic [7:0] sequence_number;
    logic [7:0] frame_length;
    logic [7:0] byte_index;
    logic [7:0] data_byte;
    kind_e      kind;
  } result_t;

endpackage

// ===== rtl/mvp_deframer.sv =====
// Deframing state machine: header capture, payload indexing, checksum skip.
// Depends on mvp_pkg.
module mvp_deframer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_i,
  input  logic [7:0]          rx_byte_i,
  output logic                res_vld_o,
  output mvp_pkg::result_t    res_o
);

  localparam logic [3:0] PH_HUNT    = 4'd0;
  localparam logic [3:0] PH_LEN     = 4'd1;
  localparam logic [3:0] PH_SEQ     = 4'd2;
  localparam logic [3:0] PH_SYS     = 4'd3;
  localparam logic [3:0] PH_COMP    = 4'd4;
  localparam logic [3:0] PH_MSG     = 4'd5;
  localparam logic [3:0] PH_PAYLOAD = 4'd6;
  localparam logic [3:0] PH_CRC1    = 4'd7;
  localparam logic [3:0] PH_CRC2    = 4'd8;

  logic [3:0] phase_q, phase_d;
  logic [7:0] len_q, len_d;
  logic [7:0] pos_q, pos_d;
  logic [7:0] seq_q, seq_d;
  logic [7:0] sys_q, sys_d;
  logic [7:0] comp_q, comp_d;
  logic [7:0] msg_q, msg_d;
  logic [7:0] pos_inc;

  assign pos_inc = pos_q + 8'd1;

  always_comb begin
    phase_d   = phase_q;
    len_d     = len_q;
    pos_d     = pos_q;
    seq_d     = seq_q;
    sys_d     = sys_q;
    comp_d    = comp_q;
    msg_d     = msg_q;
    res_vld_o = 1'b0;
    res_o.kind            = mvp_pkg::KIND_PAYLOAD;
    res_o.data_byte       = rx_byte_i;
    res_o.byte_index      = pos_q;
    res_o.frame_length    = len_q;
    res_o.sequence_number = seq_q;
    res_o.system_id       = sys_q;
    res_o.component_id    = comp_q;
    res_o.message_id      = msg_q;
    unique case (phase_q)
      PH_LEN: begin
        len_d   = rx_byte_i;
        phase_d = PH_SEQ;
      end
      PH_SEQ: begin
        seq_d   = rx_byte_i;
        phase_d = PH_SYS;
      end
      PH_SYS: begin
        sys_d   = rx_byte_i;
        phase_d = PH_COMP;
      end
      PH_COMP: begin
        comp_d  = rx_byte_i;
        phase_d = PH_MSG;
      end
      PH_MSG: begin
        msg_d   = rx_byte_i;
        pos_d   = 8'd0;
        phase_d = (len_q != 8'd0) ? PH_PAYLOAD : PH_CRC1;
      end
      PH_PAYLOAD: begin
        phase_d = PH_CRC1;
        if (pos_q < len_q) begin
          res_vld_o = 1'b1;
          pos_d     = pos_inc;
          phase_d   = (pos_inc >= len_q) ? PH_CRC1 : PH_PAYLOAD;
        end
      end
      PH_CRC1: begin
        phase_d = PH_CRC2;
      end
      PH_CRC2: begin
        res_vld_o        = 1'b1;
        res_o.kind       = mvp_pkg::KIND_EOF;
        res_o.data_byte  = 8'd0;
        res_o.byte_index = 8'd0;
        phase_d          = PH_HUNT;
      end
      default: begin
        phase_d = (rx_byte_i == mvp_pkg::START_BYTE) ? PH_LEN : PH_HUNT;
      end
    endcase
    if (!req_i) begin
      res_vld_o = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      len_q   <= 8'd0;
      pos_q   <= 8'd0;
      seq_q   <= 8'd0;
      sys_q   <= 8'd0;
      comp_q  <= 8'd0;
      msg_q   <= 8'd0;
    end else if (req_i) begin
      phase_q <= phase_d;
      len_q   <= len_d;
      pos_q   <= pos_d;
      seq_q   <= seq_d;
      sys_q   <= sys_d;
      comp_q  <= comp_d;
      msg_q   <= msg_d;
    end
  end

endmodule

// ===== rtl/mvp_out_stage.sv =====
// Result register with skid entry; the skid entry absorbs one result while output stalls.
// Depends on mvp_pkg.
module mvp_out_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  mvp_pkg::result_t    push_data_i,
  output logic                ready_o,
  output logic                valid_o,
  input  logic                pop_ready_i,
  output mvp_pkg::result_t    data_o
);

  logic             main_vld_q, main_vld_d;
  logic             skid_vld_q, skid_vld_d;
  mvp_pkg::result_t main_q, main_d;
  mvp_pkg::result_t skid_q, skid_d;
  logic             pop;

  assign pop     = main_vld_q & pop_ready_i;
  assign ready_o = ~skid_vld_q;
  assign valid_o = main_vld_q;
  assign data_o  = main_q;

  always_comb begin
    main_vld_d = main_vld_q;
    skid_vld_d = skid_vld_q;
    main_d     = main_q;
    skid_d     = skid_q;
    if (skid_vld_q) begin
      if (pop) begin
        main_d     = skid_q;
        skid_vld_d = 1'b0;
      end
    end else if (push_i) begin
      if (main_vld_q && !pop) begin
        skid_d     = push_data_i;
        skid_vld_d = 1'b1;
      end else begin
        main_d     = push_data_i;
        main_vld_d = 1'b1;
      end
    end else if (pop) begin
      main_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_vld_q <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      main_vld_q <= main_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

endmodule

// ===== rtl/mavlink_v1_frame_parser_unit.sv =====
// MAVLink v1 frame parser: one received byte per request, one byte per cycle unless stalled.
// Every byte goes through the deframer in the cycle it is accepted; payload bytes
// and the end-of-frame marker land in a result register backed by a skid entry.
// Input is stalled only when both the result register and the skid entry are full.
// Checksum bytes are skipped, never verified. Depends on mvp_pkg, mvp_deframer
// and mvp_out_stage.
module mavlink_v1_frame_parser_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [55:0] m_axis_tdata_o,   // [7:0] data_byte, [15:8] byte_index,
                                        // [23:16] frame_length, [31:24] sequence_number,
                                        // [39:32] system_id, [47:40] component_id,
                                        // [55:48] message_id
  output logic        m_axis_tuser_o    // [0] kind (0 payload, 1 end of frame)
);

  logic             req;
  logic             res_vld;
  mvp_pkg::result_t res;
  mvp_pkg::result_t out;

  assign req = s_axis_tvalid_i & s_axis_tready_o;

  mvp_deframer u_deframer (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req),
    .rx_byte_i (s_axis_tdata_i),
    .res_vld_o (res_vld),
    .res_o     (res)
  );

  mvp_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_vld),
    .push_data_i (res),
    .ready_o     (s_axis_tready_o),
    .valid_o     (m_axis_tvalid_o),
    .pop_ready_i (m_axis_tready_i),
    .data_o      (out)
  );

  assign m_axis_tdata_o = mvp_pkg::TDATA_W'({out.message_id, out.component_id,
                                             out.system_id, out.sequence_number,
                                             out.frame_length, out.byte_index,
                                             out.data_byte});
  assign m_axis_tuser_o = out.kind;

`ifndef NO_ASSERTIONS
  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o)
    else $error("input stalled with no pending result");

  a_eof_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_vld && res.kind == mvp_pkg::KIND_EOF) |->
      (res.data_byte == 8'd0 && res.byte_index == 8'd0))
    else $error("end-of-frame result carries payload data");

  a_idle_push_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_vld && !m_axis_tvalid_o) |=>
      (m_axis_tvalid_o && m_axis_tuser_o == $past(res.kind)
       && m_axis_tdata_o[7:0] == $past(res.data_byte)))
    else $error("result not presented after push into empty stage");

  a_index_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_vld && res.kind == mvp_pkg::KIND_PAYLOAD) |-> (res.byte_index < res.frame_length))
    else $error("payload index beyond frame length");
`endif

endmodule

// ===== tb/sv/tb_mavlink_v1_frame_parser_unit.sv =====
// Self-checking testbench for mavlink_v1_frame_parser_unit: directed and random byte
// streams, with a deframer predictor checking every payload and end-of-frame request.
// Depends on mvp_pkg and the parser RTL.
module tb_mavlink_v1_frame_parser_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IDLE_LIMIT = 3000;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned BYTES_PER_PASS = 170;

  typedef enum logic [3:0] {
    ST_HUNT    = 4'd0,
    ST_LEN     = 4'd1,
    ST_SEQ     = 4'd2,
    ST_SYS     = 4'd3,
    ST_COMP    = 4'd4,
    ST_MSG     = 4'd5,
    ST_PAYLOAD = 4'd6,
    ST_CRC1    = 4'd7,
    ST_CRC2    = 4'd8
  } rx_state_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;
  logic        m_tuser;

  logic [7:0]       rx_byte_q[$];
  mvp_pkg::result_t frame_result_q[$];

  int unsigned tx_gap_pct = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned err_cnt = 0;
  int unsigned idle_cnt = 0;

  rx_state_e   rx_state = ST_HUNT;
  logic [7:0]  frm_len = '0;
  logic [7:0]  pay_pos = '0;
  logic [7:0]  hdr_seq = '0;
  logic [7:0]  hdr_sys = '0;
  logic [7:0]  hdr_comp = '0;
  logic [7:0]  hdr_msg = '0;

  mavlink_v1_frame_parser_unit DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // Advances the deframer by one byte; returns 1 when the byte yields a request.
  function automatic bit deframe_byte(input logic [7:0] b, output mvp_pkg::result_t r);
    bit hit;
    hit = 1'b0;
    r = '0;
    case (rx_state)
      ST_LEN: begin
        frm_len = b;
        rx_state = ST_SEQ;
      end
      ST_SEQ: begin
        hdr_seq = b;
        rx_state = ST_SYS;
      end
      ST_SYS: begin
        hdr_sys = b;
        rx_state = ST_COMP;
      end
      ST_COMP: begin
        hdr_comp = b;
        rx_state = ST_MSG;
      end
      ST_MSG: begin
        hdr_msg = b;
        pay_pos = '0;
        rx_state = (frm_len != 8'd0) ? ST_PAYLOAD : ST_CRC1;
      end
      ST_PAYLOAD: begin
        if (pay_pos < frm_len) begin
          r.kind = mvp_pkg::KIND_PAYLOAD;
          r.data_byte = b;
          r.byte_index = pay_pos;
          hit = 1'b1;
          pay_pos = pay_pos + 8'd1;
          if (pay_pos >= frm_len) rx_state = ST_CRC1;
        end else begin
          rx_state = ST_CRC1;
        end
      end
      ST_CRC1: rx_state = ST_CRC2;
      ST_CRC2: begin
        r.kind = mvp_pkg::KIND_EOF;
        hit = 1'b1;
        rx_state = ST_HUNT;
      end
      default: rx_state = (b == mvp_pkg::START_BYTE) ? ST_LEN : ST_HUNT;
    endcase
    if (hit) begin
      r.frame_length = frm_len;
      r.sequence_number = hdr_seq;
      r.system_id = hdr_sys;
      r.component_id = hdr_comp;
      r.message_id = hdr_msg;
    end
    return hit;
  endfunction

  // header/checksum byte, biased toward the start byte
  function automatic logic [7:0] hdr_byte();
    return ($urandom_range(0, 7) == 0) ? mvp_pkg::START_BYTE : 8'($urandom_range(0, 255));
  endfunction

  task automatic queue_frame(input logic [7:0] len);
    rx_byte_q.push_back(mvp_pkg::START_BYTE);
    rx_byte_q.push_back(len);
    repeat (4) rx_byte_q.push_back(hdr_byte());
    repeat (len) rx_byte_q.push_back(8'($urandom_range(0, 255)));
    repeat (2) rx_byte_q.push_back(hdr_byte());
  endtask

  task automatic check_field(input string name, input logic [7:0] want_v,
                             input logic [7:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want_v, got_v);
      err_cnt++;
    end
  endtask

  // sender and receiver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
      s_tdata <= '0;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
      if (!s_tvalid || s_tready) begin
        if (rx_byte_q.size() != 0 && $urandom_range(0, 99) >= tx_gap_pct) begin
          s_tvalid <= 1'b1;
          s_tdata <= rx_byte_q.pop_front();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // output check first, then predict from the accepted byte
  always @(posedge clk_i) begin
    mvp_pkg::result_t got;
    mvp_pkg::result_t want;
    mvp_pkg::result_t nxt;
    if (rst_ni) begin
      if (m_tvalid && m_tready) begin
        got = mvp_pkg::result_t'({m_tdata, m_tuser});
        if (frame_result_q.size() == 0) begin
          $display("%0t: unexpected request: expected none, got %0h", $time, got);
          err_cnt++;
        end else begin
          want = frame_result_q.pop_front();
          check_field("kind", 8'(want.kind), 8'(got.kind));
          check_field("data_byte", want.data_byte, got.data_byte);
          check_field("byte_index", want.byte_index, got.byte_index);
          check_field("frame_length", want.frame_length, got.frame_length);
          check_field("sequence_number", want.sequence_number, got.sequence_number);
          check_field("system_id", want.system_id, got.system_id);
          check_field("component_id", want.component_id, got.component_id);
          check_field("message_id", want.message_id, got.message_id);
        end
      end
      if (s_tvalid && s_tready) begin
        if (deframe_byte(s_tdata, nxt)) frame_result_q.push_back(nxt);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        idle_cnt <= 0;
      end else begin
        idle_cnt <= idle_cnt + 1;
      end
      if (idle_cnt >= IDLE_LIMIT) begin
        $display("%0t: watchdog expired, %0d requests outstanding", $time,
                 frame_result_q.size());
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    int unsigned sent;
    int unsigned pick;
    logic [7:0]  len;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int pass = 0; pass < 3; pass++) begin
      case (pass)
        0: begin
          tx_gap_pct = 13;
          rx_stall_pct = 88;
        end
        1: begin
          tx_gap_pct = 88;
          rx_stall_pct = 13;
        end
        default: begin
          tx_gap_pct = 0;
          rx_stall_pct = 0;
        end
      endcase
      sent = 0;
      if (pass == 0) begin
        // zero length with extreme header and start bytes as checksum,
        // noise while hunting, then a two-byte payload with extreme values
        rx_byte_q = {8'hFE, 8'h00, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'hFE, 8'hFE,
                     8'h00, 8'hFF, 8'hFD,
                     8'hFE, 8'h02, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'h00, 8'hFF,
                     8'h12, 8'hFE};
      end
      if (pass == 2) begin
        queue_frame(8'd255);
        sent = 263;
      end
      while (sent < BYTES_PER_PASS) begin
        if ($urandom_range(0, 3) == 0) begin
          repeat ($urandom_range(1, 3)) rx_byte_q.push_back(8'($urandom_range(0, 255)));
        end
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
          len = 8'd0;
        end else if (pick == 1) begin
          len = 8'($urandom_range(13, 80));
        end else begin
          len = 8'($urandom_range(1, 12));
        end
        queue_frame(len);
        sent += len + 8;
      end
      // the next pass waits until every request of this pass has come back
      while (rx_byte_q.size() != 0 || s_tvalid || frame_result_q.size() != 0)
        @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_cnt == 0 && frame_result_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
